FILE: hdl/page_map_first_fit_allocator_macros.svh
// Assertion macros for the page map first-fit allocator.
// Used by the top level; relies on clk and rst in the including scope.
`ifndef PAGE_MAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define PAGE_MAP_FIRST_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PMFFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page map allocator check failed");

// Next-cycle implication, disabled during reset.
`define PMFFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page map allocator check failed");

`endif

FILE: hdl/pmffa_pkg.sv
// Shared types and constants for the page map first-fit allocator.
// No dependencies.
package pmffa_pkg;

  localparam int PAGE_TOTAL_DEFAULT = 4096;

  typedef enum logic [1:0] {
    OP_MAP     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RESERVE = 2'd2,
    OP_FIND    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RANGE,
    ST_FIND
  } state_t;

  typedef struct packed {
    op_t         operation;
    logic [11:0] start_page;
    logic [12:0] page_count;
    logic        mark_value;
    logic        allow_remap;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic [11:0] first_page;
    logic        range_clipped;
  } res_t;

  typedef struct packed {
    logic used_we;
    logic mark_we;
    logic used_wdata;
    logic mark_wdata;
  } mem_ctl_t;

endpackage

FILE: hdl/pmffa_bit_ram.sv
// One-bit-wide synchronous RAM with one write port and one registered read port.
// No dependencies.
module pmffa_bit_ram #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic                     wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic                     rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/pmffa_ctrl.sv
// Sequencer for the page map: clearing pass, range writes and first-fit scan.
// Depends on pmffa_pkg; drives the used and mark RAMs.
module pmffa_ctrl #(
  parameter int PAGE_TOTAL = pmffa_pkg::PAGE_TOTAL_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  pmffa_pkg::cmd_t               command,
  output logic                          done,
  output pmffa_pkg::res_t               result,
  output pmffa_pkg::mem_ctl_t           mem_ctl,
  output logic [$clog2(PAGE_TOTAL)-1:0] waddr,
  output logic [$clog2(PAGE_TOTAL)-1:0] raddr,
  input  logic                          used_rdata,
  input  logic                          mark_rdata
);

  localparam int AW = $clog2(PAGE_TOTAL);
  localparam int CW = AW + 1;
  localparam int SW = (CW > 14) ? CW : 14;
  localparam logic [SW-1:0] LIMIT = SW'(PAGE_TOTAL);

  pmffa_pkg::state_t state, state_next;
  pmffa_pkg::op_t    op, op_next;
  logic [SW-1:0]     ptr, ptr_next;
  logic [SW-1:0]     range_end, range_end_next;
  logic [SW-1:0]     rd_page, rd_page_next;
  logic [SW-1:0]     run_start, run_start_next;
  logic [12:0]       run_len, run_len_next;
  logic [12:0]       count, count_next;
  logic              mark, mark_next;
  logic              remap, remap_next;
  logic              clip, clip_next;
  logic              rd_valid, rd_valid_next;
  logic              done_next;
  pmffa_pkg::res_t   result_next;
  logic [SW-1:0]     sum;
  logic [SW-1:0]     cand;
  logic [12:0]       len_inc;
  logic              page_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pmffa_pkg::ST_CLEAR;
      ptr      <= '0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      ptr      <= ptr_next;
      rd_valid <= rd_valid_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    range_end <= range_end_next;
    rd_page   <= rd_page_next;
    run_start <= run_start_next;
    run_len   <= run_len_next;
    count     <= count_next;
    mark      <= mark_next;
    remap     <= remap_next;
    clip      <= clip_next;
    result    <= result_next;
  end

  assign busy    = (state != pmffa_pkg::ST_IDLE);
  assign page_ok = !used_rdata || (remap && mark_rdata);
  assign len_inc = run_len + 13'd1;
  assign sum     = SW'(command.start_page) + SW'(command.page_count);
  assign cand    = (run_len == 13'd0) ? rd_page : run_start;
  assign waddr   = ptr[AW-1:0];
  assign raddr   = ptr[AW-1:0];

  always_comb begin
    state_next     = state;
    op_next        = op;
    ptr_next       = ptr;
    range_end_next = range_end;
    rd_page_next   = rd_page;
    run_start_next = run_start;
    run_len_next   = run_len;
    count_next     = count;
    mark_next      = mark;
    remap_next     = remap;
    clip_next      = clip;
    rd_valid_next  = rd_valid;
    done_next      = 1'b0;
    result_next    = result;
    mem_ctl        = '0;
    unique case (state)
      pmffa_pkg::ST_CLEAR: begin
        mem_ctl.used_we = 1'b1;
        mem_ctl.mark_we = 1'b1;
        ptr_next        = ptr + SW'(1);
        if (ptr == LIMIT - SW'(1)) begin
          state_next = pmffa_pkg::ST_IDLE;
        end
      end
      pmffa_pkg::ST_IDLE: begin
        if (start) begin
          op_next       = command.operation;
          ptr_next      = SW'(command.start_page);
          count_next    = command.page_count;
          mark_next     = command.mark_value;
          remap_next    = command.allow_remap;
          run_len_next  = '0;
          rd_valid_next = 1'b0;
          if (sum > LIMIT) begin
            range_end_next = LIMIT;
            clip_next      = 1'b1;
          end else begin
            range_end_next = sum;
            clip_next      = 1'b0;
          end
          if (command.operation == pmffa_pkg::OP_FIND) begin
            state_next = pmffa_pkg::ST_FIND;
          end else begin
            state_next = pmffa_pkg::ST_RANGE;
          end
        end
      end
      pmffa_pkg::ST_RANGE: begin
        if (ptr < range_end) begin
          mem_ctl.used_we    = (op != pmffa_pkg::OP_RESERVE);
          mem_ctl.mark_we    = 1'b1;
          mem_ctl.used_wdata = (op == pmffa_pkg::OP_MAP);
          mem_ctl.mark_wdata = (op != pmffa_pkg::OP_RELEASE) && mark;
          ptr_next           = ptr + SW'(1);
        end else begin
          state_next                = pmffa_pkg::ST_IDLE;
          done_next                 = 1'b1;
          result_next.found         = 1'b0;
          result_next.first_page    = '0;
          result_next.range_clipped = clip;
        end
      end
      pmffa_pkg::ST_FIND: begin
        if (ptr < LIMIT) begin
          rd_valid_next = 1'b1;
          rd_page_next  = ptr;
          ptr_next      = ptr + SW'(1);
        end else begin
          rd_valid_next = 1'b0;
        end
        if (rd_valid) begin
          if (page_ok) begin
            run_start_next = cand;
            run_len_next   = len_inc;
            if (len_inc >= count) begin
              state_next                = pmffa_pkg::ST_IDLE;
              done_next                 = 1'b1;
              result_next.found         = 1'b1;
              result_next.first_page    = cand[11:0];
              result_next.range_clipped = 1'b0;
            end
          end else begin
            run_len_next = '0;
          end
        end else if (!(ptr < LIMIT)) begin
          state_next                = pmffa_pkg::ST_IDLE;
          done_next                 = 1'b1;
          result_next.found         = 1'b0;
          result_next.first_page    = '0;
          result_next.range_clipped = 1'b0;
        end
      end
    endcase
  end

endmodule

FILE: hdl/page_map_first_fit_allocator.sv
// Top level of the page map first-fit allocator.
// Depends on pmffa_pkg, pmffa_ctrl, pmffa_bit_ram and the assertion macro header.
//
// An item is taken on command when start is high and busy is low. Map, release
// and reserve write one page per cycle over the range, clipped at the last
// page; find scans one page per cycle from start_page through the used-bit and
// mark RAM read ports, tracking the length of the current qualifying run.
// Each item gives one result on result, marked by done for exactly one cycle;
// the receiver cannot stall it. busy is low in the cycle of done, so the next
// item can be taken then. After reset the block sweeps both RAMs to zero with
// busy high, so every page starts free and unmarked.
`include "page_map_first_fit_allocator_macros.svh"

module page_map_first_fit_allocator #(
  parameter int PAGE_TOTAL = pmffa_pkg::PAGE_TOTAL_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  pmffa_pkg::cmd_t command,
  output logic            done,
  output pmffa_pkg::res_t result
);

  localparam int AW = $clog2(PAGE_TOTAL);

  pmffa_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic                used_rdata;
  logic                mark_rdata;

  pmffa_ctrl #(
    .PAGE_TOTAL(PAGE_TOTAL)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .done      (done),
    .result    (result),
    .mem_ctl   (mem_ctl),
    .waddr     (waddr),
    .raddr     (raddr),
    .used_rdata(used_rdata),
    .mark_rdata(mark_rdata)
  );

  pmffa_bit_ram #(
    .DEPTH(PAGE_TOTAL)
  ) u_used_ram (
    .clk  (clk),
    .we   (mem_ctl.used_we),
    .waddr(waddr),
    .wdata(mem_ctl.used_wdata),
    .raddr(raddr),
    .rdata(used_rdata)
  );

  pmffa_bit_ram #(
    .DEPTH(PAGE_TOTAL)
  ) u_mark_ram (
    .clk  (clk),
    .we   (mem_ctl.mark_we),
    .waddr(waddr),
    .wdata(mem_ctl.mark_wdata),
    .raddr(raddr),
    .rdata(mark_rdata)
  );

  `PMFFA_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
  `PMFFA_ASSERT_NOW(a_done_when_idle, done, !busy)
  `PMFFA_ASSERT_NEXT(a_done_single_cycle, done, !done)
  `PMFFA_ASSERT_NOW(a_found_not_clipped, done && result.found, !result.range_clipped)

endmodule
